@@ rtl/plob_pkg.sv @@
package plob_pkg;

  localparam int LEVELS      = 64;
  localparam int PRICE_BITS  = 32;
  localparam int VOLUME_BITS = 32;
  localparam int CNT_BITS    = $clog2(LEVELS + 1);

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // broadcast to every cell of one side
  typedef struct packed {
    logic                   add;
    logic                   remove;
    logic                   any_match;
    logic                   is_ask;
    logic [PRICE_BITS-1:0]  px;
    logic [VOLUME_BITS-1:0] vol;
  } cell_cmd_t;

  // side summary used for status
  typedef struct packed {
    logic any_match;
    logic empty;
    logic full;
  } side_info_t;

endpackage

@@ rtl/price_level_order_book_top.sv @@
// an accepted beat updates the book at its edge and sets the pending flag; the result beat
// is then registered from the updated book, held back while the output is stalled
// throughput: one beat per cycle unless the output stalls; each chain of cells compares and shifts at once
// reset: rst_n synchronous active low clears both level counts and the output/pending flags;
// the level cells themselves hold no reset and are only read below the counts
module price_level_order_book_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // price[31:0], volume[63:32]
  input  logic [1:0]   in_tuser,   // side[0], kind[1]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // best_bid_price[31:0], best_bid_volume[63:32],
                                   // best_ask_price[95:64], best_ask_volume[127:96],
                                   // bid_level_count[134:128], ask_level_count[141:135],
                                   // status[143:142]
);
  import plob_pkg::*;

  logic                   in_fire;
  logic                   load;
  logic                   side;
  logic                   kind;
  logic [PRICE_BITS-1:0]  px;
  logic [VOLUME_BITS-1:0] vol;

  // pending result: the book already holds the item, the result beat is not yet built
  logic       busy_r, busy_nxt;
  logic [1:0] status_r, status_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [143:0] out_data_r;

  side_info_t             bid_info, ask_info, sel_info;
  logic [PRICE_BITS-1:0]  bid_best_price, ask_best_price;
  logic [VOLUME_BITS-1:0] bid_best_vol, ask_best_vol;
  logic [CNT_BITS-1:0]    bid_count, ask_count;

  assign side = in_tuser[0];
  assign kind = in_tuser[1];
  assign px   = in_tdata[PRICE_BITS-1:0];
  assign vol  = in_tdata[32 +: VOLUME_BITS];

  // the result is built from the updated book while busy_r is set and the output register can take it
  assign load      = busy_r && (!out_valid_r || out_tready);
  assign in_tready = !busy_r || load;
  assign in_fire   = in_tvalid && in_tready;

  plob_side u_bid (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (in_fire && (side == SIDE_BID)),
    .is_ask     (1'b0),
    .kind       (kind),
    .px         (px),
    .vol        (vol),
    .info       (bid_info),
    .best_price (bid_best_price),
    .best_vol   (bid_best_vol),
    .count_r    (bid_count)
  );

  plob_side u_ask (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (in_fire && (side == SIDE_ASK)),
    .is_ask     (1'b1),
    .kind       (kind),
    .px         (px),
    .vol        (vol),
    .info       (ask_info),
    .best_price (ask_best_price),
    .best_vol   (ask_best_vol),
    .count_r    (ask_count)
  );

  assign sel_info = (side == SIDE_ASK) ? ask_info : bid_info;

  always_comb begin
    busy_nxt      = busy_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      busy_nxt      = 1'b0;
    end
    if (in_fire) begin
      busy_nxt = 1'b1;
      if (kind == KIND_REMOVE) begin
        status_nxt = sel_info.empty ? ST_EMPTY : ST_OK;
      end else begin
        // new price on a full side: worst level drops (or the new one is not kept)
        status_nxt = (!sel_info.any_match && sel_info.full) ? ST_FULL : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (load) begin
      out_data_r <= {status_r,
                     7'(ask_count),
                     7'(bid_count),
                     32'(ask_best_vol),
                     32'(ask_best_price),
                     32'(bid_best_vol),
                     32'(bid_best_price)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/plob_cell.sv @@
module plob_cell (
  input  logic                             clk,
  input  plob_pkg::cell_cmd_t              cmd,
  input  logic                             valid,
  input  logic                             left_ahead,
  input  logic [plob_pkg::PRICE_BITS-1:0]  left_price,
  input  logic [plob_pkg::VOLUME_BITS-1:0] left_vol,
  input  logic [plob_pkg::PRICE_BITS-1:0]  right_price,
  input  logic [plob_pkg::VOLUME_BITS-1:0] right_vol,
  output logic [plob_pkg::PRICE_BITS-1:0]  price_r,
  output logic [plob_pkg::VOLUME_BITS-1:0] vol_r,
  output logic                             match,
  output logic                             ahead
);
  import plob_pkg::*;

  logic [PRICE_BITS-1:0]  price_nxt;
  logic [VOLUME_BITS-1:0] vol_nxt;
  logic [VOLUME_BITS:0]   sum;

  // invalid slots count as ahead so the first free slot takes a new level
  assign match = valid && (price_r == cmd.px);
  assign ahead = !valid || (cmd.is_ask ? (cmd.px < price_r) : (cmd.px > price_r));
  assign sum   = {1'b0, vol_r} + {1'b0, cmd.vol};

  always_comb begin
    price_nxt = price_r;
    vol_nxt   = vol_r;
    if (cmd.remove) begin
      price_nxt = right_price;
      vol_nxt   = right_vol;
    end else if (cmd.add) begin
      if (cmd.any_match) begin
        if (match) begin
          vol_nxt = sum[VOLUME_BITS] ? {VOLUME_BITS{1'b1}} : sum[VOLUME_BITS-1:0];
        end
      end else if (left_ahead) begin
        price_nxt = left_price;
        vol_nxt   = left_vol;
      end else if (ahead) begin
        price_nxt = cmd.px;
        vol_nxt   = cmd.vol;
      end
    end
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    vol_r   <= vol_nxt;
  end

endmodule

@@ rtl/plob_side.sv @@
module plob_side (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             is_ask,
  input  logic                             kind,
  input  logic [plob_pkg::PRICE_BITS-1:0]  px,
  input  logic [plob_pkg::VOLUME_BITS-1:0] vol,
  output plob_pkg::side_info_t             info,
  output logic [plob_pkg::PRICE_BITS-1:0]  best_price,
  output logic [plob_pkg::VOLUME_BITS-1:0] best_vol,
  output logic [plob_pkg::CNT_BITS-1:0]    count_r
);
  import plob_pkg::*;

  logic [CNT_BITS-1:0]    count_nxt;
  logic [LEVELS-1:0]      valid;
  logic [LEVELS-1:0]      match;
  logic [LEVELS-1:0]      ahead;
  logic [PRICE_BITS-1:0]  price  [LEVELS];
  logic [VOLUME_BITS-1:0] volume [LEVELS];
  cell_cmd_t              cmd;

  assign info.any_match = |match;
  assign info.empty     = (count_r == '0);
  assign info.full      = (count_r == CNT_BITS'(LEVELS));

  assign cmd.add       = en && (kind == KIND_ADD);
  assign cmd.remove    = en && (kind == KIND_REMOVE) && !info.empty;
  assign cmd.any_match = info.any_match;
  assign cmd.is_ask    = is_ask;
  assign cmd.px        = px;
  assign cmd.vol       = vol;

  genvar i;
  generate
    for (i = 0; i < LEVELS; i++) begin : g_cell
      assign valid[i] = (count_r > CNT_BITS'(i));
      if (i == 0) begin : g_head
        plob_cell u_cell (
          .clk         (clk),
          .cmd         (cmd),
          .valid       (valid[i]),
          .left_ahead  (1'b0),
          .left_price  (price[i]),
          .left_vol    (volume[i]),
          .right_price (price[i+1]),
          .right_vol   (volume[i+1]),
          .price_r     (price[i]),
          .vol_r       (volume[i]),
          .match       (match[i]),
          .ahead       (ahead[i])
        );
      end else if (i == LEVELS - 1) begin : g_tail
        plob_cell u_cell (
          .clk         (clk),
          .cmd         (cmd),
          .valid       (valid[i]),
          .left_ahead  (ahead[i-1]),
          .left_price  (price[i-1]),
          .left_vol    (volume[i-1]),
          .right_price (price[i]),
          .right_vol   (volume[i]),
          .price_r     (price[i]),
          .vol_r       (volume[i]),
          .match       (match[i]),
          .ahead       (ahead[i])
        );
      end else begin : g_mid
        plob_cell u_cell (
          .clk         (clk),
          .cmd         (cmd),
          .valid       (valid[i]),
          .left_ahead  (ahead[i-1]),
          .left_price  (price[i-1]),
          .left_vol    (volume[i-1]),
          .right_price (price[i+1]),
          .right_vol   (volume[i+1]),
          .price_r     (price[i]),
          .vol_r       (volume[i]),
          .match       (match[i]),
          .ahead       (ahead[i])
        );
      end
    end
  endgenerate

  assign best_price = info.empty ? '0 : price[0];
  assign best_vol   = info.empty ? '0 : volume[0];

  always_comb begin
    count_nxt = count_r;
    if (cmd.remove) begin
      count_nxt = count_r - 1'b1;
    end else if (cmd.add && !info.any_match && !info.full) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ bench/price_level_order_book_top_tb.sv @@
module price_level_order_book_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plob_pkg::*;

  localparam int TOTAL_ORDERS = 1550;  // directed plus random order beats
  localparam int QUIET_TAIL   = 150;   // last beats run with no idling on either side
  localparam int LONG_HOLD    = 300;   // cycles the receiver holds off once
  localparam int STALL_LIMIT  = 3000;  // cycles with no handshake before giving up

  // one quote beat as packed on out_tdata, lowest field last
  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  ask_cnt;
    logic [6:0]  bid_cnt;
    logic [31:0] ask_vol;
    logic [31:0] ask_px;
    logic [31:0] bid_vol;
    logic [31:0] bid_px;
  } quote_t;

  // shadow book: sorted levels per side, best first, plus the quotes still due
  class book_tracker;
    bit [31:0] level_px  [2][LEVELS];
    bit [31:0] level_vol [2][LEVELS];
    int unsigned depth [2];
    quote_t quotes_due[$];
    int mismatches;
    int quotes_checked;
    int full_drops;
    int empty_removes;
    int saturations;

    function new();
      depth[0] = 0;
      depth[1] = 0;
    endfunction

    function bit ranks_ahead(bit ask, bit [31:0] a, bit [31:0] b);
      return ask ? (a < b) : (a > b);
    endfunction

    function logic [1:0] add_volume(bit s, bit [31:0] p, bit [31:0] v);
      int unsigned n;
      int unsigned slot;
      bit [32:0] sum;
      logic [1:0] st;
      st = ST_OK;
      n = depth[s];
      slot = n;
      for (int i = 0; i < n; i++) begin
        if (level_px[s][i] == p) begin
          sum = {1'b0, level_vol[s][i]} + {1'b0, v};
          if (sum[32]) begin
            level_vol[s][i] = '1;
            saturations++;
          end else begin
            level_vol[s][i] = sum[31:0];
          end
          return ST_OK;
        end
        if (ranks_ahead(s, p, level_px[s][i])) begin
          slot = i;
          break;
        end
      end
      if (n == LEVELS) begin
        full_drops++;
        st = ST_FULL;
        // the new price is the worst of all: nothing is stored
        if (slot >= LEVELS) return st;
        n = LEVELS - 1;
      end
      for (int k = n; k > slot; k--) begin
        level_px[s][k]  = level_px[s][k-1];
        level_vol[s][k] = level_vol[s][k-1];
      end
      level_px[s][slot]  = p;
      level_vol[s][slot] = v;
      depth[s] = n + 1;
      return st;
    endfunction

    function logic [1:0] remove_top(bit s);
      if (depth[s] == 0) begin
        empty_removes++;
        return ST_EMPTY;
      end
      for (int k = 1; k < depth[s]; k++) begin
        level_px[s][k-1]  = level_px[s][k];
        level_vol[s][k-1] = level_vol[s][k];
      end
      depth[s] = depth[s] - 1;
      return ST_OK;
    endfunction

    function void note_order(bit s, bit k, bit [31:0] p, bit [31:0] v);
      quote_t q;
      logic [1:0] st;
      if (k == KIND_REMOVE) begin
        st = remove_top(s);
      end else begin
        st = add_volume(s, p, v);
      end
      q.status  = st;
      q.bid_cnt = depth[0][6:0];
      q.ask_cnt = depth[1][6:0];
      q.bid_px  = depth[0] != 0 ? level_px[0][0]  : 32'd0;
      q.bid_vol = depth[0] != 0 ? level_vol[0][0] : 32'd0;
      q.ask_px  = depth[1] != 0 ? level_px[1][0]  : 32'd0;
      q.ask_vol = depth[1] != 0 ? level_vol[1][0] : 32'd0;
      quotes_due.push_back(q);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_quote(quote_t got);
      quote_t want;
      if (quotes_due.size() == 0) begin
        $display("%0t: quote beat with nothing due, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = quotes_due.pop_front();
      quotes_checked++;
      compare("best_bid_price", want.bid_px, got.bid_px);
      compare("best_bid_volume", want.bid_vol, got.bid_vol);
      compare("best_ask_price", want.ask_px, got.ask_px);
      compare("best_ask_volume", want.ask_vol, got.ask_vol);
      compare("bid_level_count", want.bid_cnt, got.bid_cnt);
      compare("ask_level_count", want.ask_cnt, got.ask_cnt);
      compare("status", want.status, got.status);
    endfunction

    function int pending();
      return quotes_due.size();
    endfunction
  endclass

  // clock and reset, every input known from time zero
  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;    // price[31:0], volume[63:32]
  logic [1:0]   in_tuser = '0;    // side[0], kind[1]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;        // bid px, bid vol, ask px, ask vol, counts, status

  book_tracker sb = new();

  bit quiet = 1'b0;       // final stretch: no idling anywhere
  bit hold_req = 1'b0;    // asks the receiver for its one long hold-off
  int orders_sent = 0;
  int idle_cycles = 0;

  price_level_order_book_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // input monitor: every accepted order beat updates the shadow book
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_order(in_tuser[0], in_tuser[1], in_tdata[31:0], in_tdata[63:32]);
    end
  end

  // output monitor: every accepted quote beat is checked against the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_quote(quote_t'(out_tdata));
    end
  end

  // watchdog on cycles where neither side moves a beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d quotes still due", $time,
               idle_cycles, sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request, none at the end
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // offer one order beat and wait for it to be taken; valid stays high afterwards
  task automatic send_order(input logic s, input logic k, input logic [31:0] p,
                            input logic [31:0] v);
    in_tvalid <= 1'b1;
    in_tuser  <= {k, s};
    in_tdata  <= {v, p};
    do @(posedge clk); while (!in_tready);
    orders_sent++;
  endtask

  // sender gap: in_tvalid held low for a random span drawn by $urandom_range
  task automatic sender_gap();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 17)) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_volume();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return $urandom();
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  function automatic logic [31:0] rand_base();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 300);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int scenario;
    int n;
    int span;
    bit gappy;
    bit hold_done;
    bit pause_done;
    logic s;
    logic k;
    logic book_side;
    logic [31:0] base;
    logic [31:0] p;
    logic [31:0] v;

    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty removes, extreme prices and volumes, saturation, mid inserts
    send_order(SIDE_BID, KIND_REMOVE, 32'd0, 32'd0);
    send_order(SIDE_ASK, KIND_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(SIDE_BID, KIND_ADD, 32'd0, 32'd0);                  // zero volume still a level
    send_order(SIDE_BID, KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(SIDE_BID, KIND_ADD, 32'hFFFF_FFFF, 32'd1);          // saturates
    send_order(SIDE_BID, KIND_ADD, 32'd0, 32'd5);                  // existing price sums
    sender_gap();
    send_order(SIDE_ASK, KIND_ADD, 32'hFFFF_FFFF, 32'd0);
    send_order(SIDE_ASK, KIND_ADD, 32'd0, 32'hFFFF_FFFF);
    send_order(SIDE_ASK, KIND_ADD, 32'd0, 32'hFFFF_FFFF);          // saturates
    send_order(SIDE_ASK, KIND_ADD, 32'd100, 32'd7);
    send_order(SIDE_BID, KIND_ADD, 32'd100, 32'd3);
    send_order(SIDE_BID, KIND_REMOVE, 32'd0, 32'd0);
    send_order(SIDE_ASK, KIND_REMOVE, 32'd0, 32'd0);
    send_order(SIDE_ASK, KIND_REMOVE, 32'd0, 32'd0);
    send_order(SIDE_ASK, KIND_REMOVE, 32'd0, 32'd0);
    send_order(SIDE_ASK, KIND_REMOVE, 32'd0, 32'd0);               // remove on an already empty side
    send_order(SIDE_ASK, KIND_ADD, 32'h8000_0000, 32'h5555_5555);
    send_order(SIDE_BID, KIND_ADD, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_order(SIDE_BID, KIND_ADD, 32'h5555_5555, 32'h8000_0000);
    send_order(SIDE_ASK, KIND_ADD, 32'h7FFF_FFFF, 32'h0000_0001);

    // random blocks: fill a side past full, drain, pile volume on few prices, noise
    while (orders_sent < TOTAL_ORDERS) begin
      if (!hold_done && orders_sent > 450) begin
        hold_req = 1'b1;       // sender keeps offering while the receiver holds
        hold_done = 1'b1;
      end
      if (!pause_done && orders_sent > 900) begin
        in_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        pause_done = 1'b1;
      end
      scenario  = $urandom_range(0, 9);
      book_side = 1'($urandom_range(0, 1));
      base      = rand_base();
      span      = $urandom_range(40, 300);
      gappy     = $urandom_range(0, 2) != 0;
      n         = (scenario < 4) ? $urandom_range(60, 120) : $urandom_range(10, 60);
      for (int j = 0; j < n && orders_sent < TOTAL_ORDERS; j++) begin
        s = ($urandom_range(0, 4) == 0) ? !book_side : book_side;
        p = base + $urandom_range(0, span);
        v = rand_volume();
        if (scenario < 4) begin
          k = ($urandom_range(0, 6) == 0) ? KIND_REMOVE : KIND_ADD;
        end else if (scenario < 6) begin
          k = ($urandom_range(0, 4) != 0) ? KIND_REMOVE : KIND_ADD;
        end else if (scenario < 8) begin
          k = ($urandom_range(0, 9) == 0) ? KIND_REMOVE : KIND_ADD;
          p = base + $urandom_range(0, 3);
          if ($urandom_range(0, 1)) v = 32'hFFFF_FFFF - $urandom_range(0, 255);
        end else begin
          s = 1'($urandom_range(0, 1));
          k = 1'($urandom_range(0, 1));
          p = $urandom();
          v = $urandom();
        end
        send_order(s, k, p, v);
        quiet = orders_sent >= TOTAL_ORDERS - QUIET_TAIL;
        if (!quiet && gappy && $urandom_range(0, 5) == 0) sender_gap();
      end
    end
    in_tvalid <= 1'b0;

    // drain, then wait on to catch any stray quote
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d orders sent, %0d quotes checked", orders_sent, sb.quotes_checked);
    $display("%0d full-side drops, %0d removes on an empty side, %0d saturating adds",
             sb.full_drops, sb.empty_removes, sb.saturations);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
